>>> sv/drt_pkg.sv
// shared types and constants for the open row tracker
`timescale 1ns / 1ps
`default_nettype none

package drt_pkg;

  localparam int ADDR_W     = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;
  localparam int POS_W      = 7;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LAYOUT     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INTERLEAVE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_W   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_COLUMN_W   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PAGE_W     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_W      = 3'd5;

  // field order above the row
  localparam logic [1:0] LAYOUT_CH_DM_RK = 2'd0;
  localparam logic [1:0] LAYOUT_DM_CH_RK = 2'd1;
  localparam logic [1:0] LAYOUT_DM_RK_CH = 2'd2;

  localparam logic MODE_BLOCK = 1'b0;
  localparam logic MODE_ROW   = 1'b1;

  localparam logic [1:0] RST_LAYOUT     = LAYOUT_CH_DM_RK;
  localparam logic       RST_INTERLEAVE = MODE_BLOCK;
  localparam logic [2:0] RST_OFFSET_W   = 3'd3;
  localparam logic [3:0] RST_COLUMN_W   = 4'd7;
  localparam logic [3:0] RST_PAGE_W     = 4'd4;
  localparam logic [4:0] RST_ROW_W      = 5'd14;

  typedef struct packed {
    logic capture;
    logic commit;
  } drt_cmd_t;

  // up to two address bits taken from pos, n bits wide (n at most 2)
  function automatic logic [1:0] field2(input logic [ADDR_W-1:0] a,
                                        input logic [POS_W-1:0] pos,
                                        input logic [1:0] n);
    logic [ADDR_W-1:0] sh;
    sh = a >> pos;
    return sh[1:0] & ~(2'b11 << n);
  endfunction

endpackage

`default_nettype wire

>>> sv/drt_intf.sv
// handshake interfaces for address, result and configuration channels
`timescale 1ns / 1ps
`default_nettype none

interface drt_addr_if;
  logic                        valid;
  logic                        ready;
  logic [drt_pkg::ADDR_W-1:0]  address;
  modport source (output valid, output address, input ready);
  modport sink   (input valid, input address, output ready);
endinterface

interface drt_miss_if;
  logic valid;
  logic ready;
  logic row_miss;
  modport source (output valid, output row_miss, input ready);
  modport sink   (input valid, input row_miss, output ready);
endinterface

interface drt_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [drt_pkg::CFG_IDX_W-1:0]  index;
  logic [drt_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> sv/drt_ram.sv
// generic single port ram with lane write enables and registered read
`timescale 1ns / 1ps
`default_nettype none

module drt_ram #(
  parameter int WIDTH = 128,
  parameter int DEPTH = 8,
  parameter int LANES = 8
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 re_i,
  input  wire logic [LANES-1:0]                     lane_we_i,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr_i,
  input  wire logic [WIDTH-1:0]                     wdata_i,
  output logic      [WIDTH-1:0]                     rdata_o
);

  localparam int LANE_W = WIDTH / LANES;

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    for (int l = 0; l < LANES; l++) begin
      if (lane_we_i[l]) begin
        mem_q[addr_i][l*LANE_W +: LANE_W] <= wdata_i[l*LANE_W +: LANE_W];
      end
    end
    if (re_i) begin
      rdata_o <= mem_q[addr_i];
    end
  end

endmodule

`default_nettype wire

>>> sv/drt_ctrl.sv
// sequencing of one access: capture, compare and update, result register
`timescale 1ns / 1ps
`default_nettype none

module drt_ctrl (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output drt_pkg::drt_cmd_t cmd_o
);

  typedef enum logic {
    S_IDLE,
    S_CMP
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    in_ready_o    = (state_q == S_IDLE);
    cmd_o.capture = (state_q == S_IDLE) && in_valid_i;
    // compare only when the result register is free or drains this cycle
    cmd_o.commit  = (state_q == S_CMP) && (!out_valid_q || out_ready_i);
    state_d       = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_CMP;
      end
      S_CMP: begin
        if (cmd_o.commit) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
    if (cmd_o.commit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

>>> sv/drt_datapath.sv
// config registers, address decode, open row store and row compare
`timescale 1ns / 1ps
`default_nettype none

module drt_datapath #(
  parameter int CHANNEL_BITS = 1,
  parameter int DIMM_BITS    = 1,
  parameter int RANK_BITS    = 1,
  parameter int BANK_BITS    = 3,
  parameter int ROW_BITS     = 16,
  parameter int ADDR_BITS    = 32
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [drt_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire logic [drt_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  wire logic [drt_pkg::ADDR_W-1:0]       address_i,
  input  wire drt_pkg::drt_cmd_t                cmd_i,
  output logic                                  row_miss_o
);

  localparam int SLOT_BITS = CHANNEL_BITS + DIMM_BITS + RANK_BITS + BANK_BITS;
  localparam int RSEL_BITS = CHANNEL_BITS + DIMM_BITS + RANK_BITS;
  localparam int RANK_AW   = RSEL_BITS > 0 ? RSEL_BITS : 1;
  localparam int RANKS     = 1 << RSEL_BITS;
  localparam int BANKS     = 1 << BANK_BITS;
  localparam int SLOTS     = 1 << SLOT_BITS;
  localparam int ADDR_USED = ADDR_BITS < drt_pkg::ADDR_W ? ADDR_BITS : drt_pkg::ADDR_W;
  localparam logic [drt_pkg::ADDR_W-1:0] ADDR_MASK =
    {drt_pkg::ADDR_W{1'b1}} >> (drt_pkg::ADDR_W - ADDR_USED);
  localparam int PW = drt_pkg::POS_W;

  // configuration registers
  logic [1:0] layout_q;
  logic       mode_q;
  logic [2:0] offset_w_q;
  logic [3:0] column_w_q;
  logic [3:0] page_w_q;
  logic [4:0] row_w_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      layout_q   <= drt_pkg::RST_LAYOUT;
      mode_q     <= drt_pkg::RST_INTERLEAVE;
      offset_w_q <= drt_pkg::RST_OFFSET_W;
      column_w_q <= drt_pkg::RST_COLUMN_W;
      page_w_q   <= drt_pkg::RST_PAGE_W;
      row_w_q    <= drt_pkg::RST_ROW_W;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        drt_pkg::CFG_LAYOUT:     layout_q   <= cfg_data_i[1:0];
        drt_pkg::CFG_INTERLEAVE: mode_q     <= cfg_data_i[0];
        drt_pkg::CFG_OFFSET_W:   offset_w_q <= cfg_data_i[2:0];
        drt_pkg::CFG_COLUMN_W:   column_w_q <= cfg_data_i[3:0];
        drt_pkg::CFG_PAGE_W:     page_w_q   <= cfg_data_i[3:0];
        drt_pkg::CFG_ROW_W:      row_w_q    <= cfg_data_i[4:0];
        default: ;
      endcase
    end
  end

  // address decode
  logic [drt_pkg::ADDR_W-1:0] addr;
  logic [4:0]                 rw;
  logic [PW-1:0]              base, top, bank_pos;
  logic [drt_pkg::ADDR_W-1:0] row_sh, bank_sh;
  logic [ROW_BITS-1:0]        row, row_mask;
  logic [1:0]                 ch, dm, rk;
  logic [BANK_BITS-1:0]       bank;
  logic [31:0]                slot_wide;
  logic [RANK_AW-1:0]         rank;

  always_comb begin
    addr     = address_i & ADDR_MASK;
    rw       = (row_w_q > 5'(ROW_BITS)) ? 5'(ROW_BITS) : row_w_q;
    base     = PW'(offset_w_q) + PW'(column_w_q) + PW'(BANK_BITS);
    top      = base + PW'(rw);
    row_sh   = addr >> base;
    row_mask = ~({ROW_BITS{1'b1}} << rw);
    row      = row_sh[ROW_BITS-1:0] & row_mask;
    unique case (layout_q)
      drt_pkg::LAYOUT_DM_CH_RK: begin
        rk = drt_pkg::field2(addr, top, 2'(RANK_BITS));
        ch = drt_pkg::field2(addr, top + PW'(RANK_BITS), 2'(CHANNEL_BITS));
        dm = drt_pkg::field2(addr, top + PW'(RANK_BITS + CHANNEL_BITS), 2'(DIMM_BITS));
      end
      drt_pkg::LAYOUT_DM_RK_CH: begin
        ch = drt_pkg::field2(addr, top, 2'(CHANNEL_BITS));
        rk = drt_pkg::field2(addr, top + PW'(CHANNEL_BITS), 2'(RANK_BITS));
        dm = drt_pkg::field2(addr, top + PW'(CHANNEL_BITS + RANK_BITS), 2'(DIMM_BITS));
      end
      default: begin
        // unused code decodes like channel above dimm above rank
        rk = drt_pkg::field2(addr, top, 2'(RANK_BITS));
        dm = drt_pkg::field2(addr, top + PW'(RANK_BITS), 2'(DIMM_BITS));
        ch = drt_pkg::field2(addr, top + PW'(RANK_BITS + DIMM_BITS), 2'(CHANNEL_BITS));
      end
    endcase
    if (mode_q == drt_pkg::MODE_ROW) begin
      bank_pos = PW'(offset_w_q) + PW'(page_w_q);
    end else begin
      bank_pos = PW'(offset_w_q) + PW'(column_w_q);
    end
    bank_sh   = addr >> bank_pos;
    bank      = bank_sh[BANK_BITS-1:0];
    slot_wide = (32'(ch) << (DIMM_BITS + RANK_BITS + BANK_BITS))
              | (32'(dm) << (RANK_BITS + BANK_BITS))
              | (32'(rk) << BANK_BITS)
              | 32'(bank);
    rank      = slot_wide[BANK_BITS +: RANK_AW];
  end

  // decoded item, held through the compare cycle
  logic [ROW_BITS-1:0]  row_q;
  logic [BANK_BITS-1:0] bank_q;
  logic [RANK_AW-1:0]   rank_q;
  logic [SLOT_BITS-1:0] slot_q;
  logic                 miss_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      row_q  <= row;
      bank_q <= bank;
      rank_q <= rank;
      slot_q <= slot_wide[SLOT_BITS-1:0];
    end
  end

  // open rows, one ram word per rank with one lane per bank
  logic [BANKS-1:0]          lane_we;
  logic [BANKS*ROW_BITS-1:0] rdata;
  logic [RANK_AW-1:0]        ram_addr;
  logic [ROW_BITS-1:0]       open_row;

  always_comb begin
    ram_addr = cmd_i.capture ? rank : rank_q;
    lane_we  = '0;
    if (cmd_i.commit) begin
      if (mode_q == drt_pkg::MODE_ROW) begin
        lane_we = '1;
      end else begin
        lane_we[bank_q] = 1'b1;
      end
    end
    open_row = rdata[bank_q*ROW_BITS +: ROW_BITS];
  end

  drt_ram #(
    .WIDTH (BANKS * ROW_BITS),
    .DEPTH (RANKS),
    .LANES (BANKS)
  ) u_open_row (
    .clk_i     (clk_i),
    .re_i      (cmd_i.capture),
    .lane_we_i (lane_we),
    .addr_i    (ram_addr),
    .wdata_i   ({BANKS{row_q}}),
    .rdata_o   (rdata)
  );

  // per bank valid flags, cleared by reset
  logic [SLOTS-1:0] valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (cmd_i.commit) begin
      for (int s = 0; s < SLOTS; s++) begin
        if (mode_q == drt_pkg::MODE_ROW) begin
          if ((SLOT_BITS'(s) >> BANK_BITS) == (slot_q >> BANK_BITS)) valid_q[s] <= 1'b1;
        end else begin
          if (SLOT_BITS'(s) == slot_q) valid_q[s] <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      miss_q <= !valid_q[slot_q] || (open_row != row_q);
    end
  end

  assign row_miss_o = miss_q;

endmodule

`default_nettype wire

>>> sv/dram_open_row_tracker.sv
// dram open row tracker: an address is captured with the open row ram read,
// then compared and updated, and its row miss goes to the output register; the next
// address is accepted only after that compare and update, but a result waiting in the
// output register does not stop the next address from being accepted
// reset: config registers take their defaults and every bank's valid flag clears at once;
// a bank misses until written, or in row mode until its rank is written; no clearing pass
`timescale 1ns / 1ps
`default_nettype none

module dram_open_row_tracker #(
  parameter int CHANNEL_BITS = 1,
  parameter int DIMM_BITS    = 1,
  parameter int RANK_BITS    = 1,
  parameter int BANK_BITS    = 3,
  parameter int ROW_BITS     = 16,
  parameter int ADDR_BITS    = 32
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  drt_addr_if.sink   addr_i,
  drt_miss_if.source miss_o,
  drt_cfg_if.sink    cfg_i
);

  drt_pkg::drt_cmd_t cmd;

  assign cfg_i.ready = 1'b1;

  drt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (addr_i.valid),
    .in_ready_o  (addr_i.ready),
    .out_valid_o (miss_o.valid),
    .out_ready_i (miss_o.ready),
    .cmd_o       (cmd)
  );

  drt_datapath #(
    .CHANNEL_BITS (CHANNEL_BITS),
    .DIMM_BITS    (DIMM_BITS),
    .RANK_BITS    (RANK_BITS),
    .BANK_BITS    (BANK_BITS),
    .ROW_BITS     (ROW_BITS),
    .ADDR_BITS    (ADDR_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_i.valid),
    .cfg_index_i (cfg_i.index),
    .cfg_data_i  (cfg_i.data),
    .address_i   (addr_i.address),
    .cmd_i       (cmd),
    .row_miss_o  (miss_o.row_miss)
  );

endmodule

`default_nettype wire
